// ===== hdl/dsmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsmc_pkg
// Shared types, codes and motor math for the drive safety mode controller.
// ----------------------------------------------------------------------------
package dsmc_pkg;

	typedef enum logic [3:0] {
		OP_TICK        = 4'd0,
		OP_PING        = 4'd1,
		OP_STATUS      = 4'd2,
		OP_STOP        = 4'd3,
		OP_ESTOP       = 4'd4,
		OP_CLEAR_FAULT = 4'd5,
		OP_SET_MODE    = 4'd6,
		OP_START_ROW   = 4'd7,
		OP_MANUAL      = 4'd8,
		OP_UNKNOWN     = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_MANUAL = 2'd1,
		MODE_AUTO   = 2'd2,
		MODE_FAULT  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REQ_IDLE    = 2'd0,
		REQ_MANUAL  = 2'd1,
		REQ_AUTO    = 2'd2,
		REQ_INVALID = 2'd3
	} mode_req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BLOCKED = 3'd1,
		ST_UNSAFE  = 3'd2,
		ST_BAD     = 3'd3,
		ST_UNKNOWN = 3'd4,
		ST_ESTOP   = 3'd5,
		ST_BUTTON  = 3'd6,
		ST_EDGE    = 3'd7
	} status_t;

	localparam logic CFG_SENSE_LIMIT = 1'b0;
	localparam logic CFG_ROW_SPEED   = 1'b1;

	localparam logic [11:0]       SENSE_LIMIT_RST = 12'd1000;
	localparam logic signed [9:0] ROW_SPEED_RST   = 10'sd128;
	localparam logic signed [9:0] DEADBAND        = 10'sd12;
	localparam logic signed [9:0] TRACK_MAX       = 10'sd256;
	localparam logic signed [9:0] WIPE_FULL       = 10'sd256;

	// classified command, front to back
	typedef struct packed {
		op_t                op;
		mode_req_t          mode_req;
		logic               pressed;
		logic               unsafe;
		logic signed [9:0]  auto_drive;
		logic signed [9:0]  drive;
		logic signed [9:0]  turn;
		logic signed [9:0]  wipe;
	} work_t;

	typedef struct packed {
		logic [7:0] left_fwd;
		logic [7:0] left_rev;
		logic [7:0] right_fwd;
		logic [7:0] right_rev;
		logic [7:0] wiper;
	} pwm_t;

	// floor(mag * 255 / 256), mag in 0..256
	function automatic logic [7:0] duty(input logic [8:0] mag);
		logic [16:0] p;
		p = {mag, 8'd0} - 17'(mag);
		return p[15:8];
	endfunction

	// clamp(a +/- b, -256, 256)
	function automatic logic signed [9:0] track_mix(input logic signed [9:0] a,
		input logic signed [9:0] b, input logic diff);
		logic signed [10:0] s;
		s = diff ? (11'(a) - 11'(b)) : (11'(a) + 11'(b));
		if (s > 11'sd256)
			return TRACK_MAX;
		else if (s < -11'sd256)
			return -TRACK_MAX;
		else
			return s[9:0];
	endfunction

	// {fwd, rev} duties of one H-bridge with deadband
	function automatic logic [15:0] bridge(input logic signed [9:0] v);
		logic [9:0] mag;
		logic [7:0] d;
		mag = v[9] ? 10'(-v) : 10'(v);
		d = duty(mag[8:0]);
		if (v > DEADBAND)
			return {d, 8'd0};
		else if (v < -DEADBAND)
			return {8'd0, d};
		else
			return 16'd0;
	endfunction

	function automatic logic [7:0] wiper_duty(input logic signed [9:0] w);
		logic [8:0] m;
		if (w < 10'sd0)
			m = 9'd0;
		else if (w > WIPE_FULL)
			m = 9'd256;
		else
			m = w[8:0];
		return duty(m);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/dsmc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsmc interfaces
// Command, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsmc_cmd_if;
	logic              valid;
	logic              ready;
	logic [3:0]        func;
	logic [1:0]        mode_request;
	logic              speed_given;
	logic signed [9:0] speed;
	logic signed [9:0] drive_req;
	logic signed [9:0] turn_req;
	logic signed [9:0] wipe_req;
	logic [11:0]       edge_front_left;
	logic [11:0]       edge_front_right;
	logic [11:0]       edge_rear_left;
	logic [11:0]       edge_rear_right;
	logic              button_released;

	modport source (output valid, func, mode_request, speed_given, speed, drive_req,
		turn_req, wipe_req, edge_front_left, edge_front_right, edge_rear_left,
		edge_rear_right, button_released, input ready);
	modport sink (input valid, func, mode_request, speed_given, speed, drive_req,
		turn_req, wipe_req, edge_front_left, edge_front_right, edge_rear_left,
		edge_rear_right, button_released, output ready);
endinterface

interface dsmc_rsp_if;
	logic       valid;
	logic       ready;
	logic       reply_sent;
	logic [2:0] status;
	logic [1:0] mode_now;
	logic       pong;
	logic       edge_alarm;
	logic       fault_latched;
	logic [7:0] left_fwd_pwm;
	logic [7:0] left_rev_pwm;
	logic [7:0] right_fwd_pwm;
	logic [7:0] right_rev_pwm;
	logic [7:0] wiper_pwm;

	modport source (output valid, reply_sent, status, mode_now, pong, edge_alarm,
		fault_latched, left_fwd_pwm, left_rev_pwm, right_fwd_pwm, right_rev_pwm,
		wiper_pwm, input ready);
	modport sink (input valid, reply_sent, status, mode_now, pong, edge_alarm,
		fault_latched, left_fwd_pwm, left_rev_pwm, right_fwd_pwm, right_rev_pwm,
		wiper_pwm, output ready);
endinterface

interface dsmc_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [11:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/drive_safety_mode_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A command beat is registered in the queue, then in the response register.
// Throughput: one beat and one command per cycle unless rsp.ready stalls.
// Response register decouples rsp.ready; the queue absorbs QUEUE_DEPTH beats.
// Reset: async active low; mode idle, fault clear, commands and duties zero,
// sensor limit 1000, row speed 128, no clearing pass.
// ----------------------------------------------------------------------------
// drive_safety_mode_controller
// Safety mode controller for a two-track robot with wiper: decode front,
// command queue, execution back end and configuration registers.
// ----------------------------------------------------------------------------
module drive_safety_mode_controller
	import dsmc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	dsmc_cmd_if.sink   cmd,
	dsmc_rsp_if.source rsp,
	dsmc_cfg_if.sink   cfg
);

	logic [11:0]       sense_limit_q;
	logic signed [9:0] row_speed_q;
	logic              push_valid;
	logic              push_ready;
	work_t             push_data;
	logic              pop_valid;
	logic              pop_ready;
	work_t             pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_limit_q <= SENSE_LIMIT_RST;
			row_speed_q   <= ROW_SPEED_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_SENSE_LIMIT) begin
				sense_limit_q <= cfg.data;
			end else if (cfg.index == CFG_ROW_SPEED) begin
				row_speed_q <= cfg.data[9:0];
			end
		end
	end

	dsmc_front u_front (
		.cmd         (cmd),
		.sense_limit (sense_limit_q),
		.row_speed   (row_speed_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	dsmc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dsmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

	a_fault_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.fault_latched == (rsp.mode_now == MODE_FAULT)))
		else $error("fault latch and fault mode disagree");

	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.mode_now == MODE_FAULT) |->
		(rsp.left_fwd_pwm == 8'd0 && rsp.left_rev_pwm == 8'd0 &&
		rsp.right_fwd_pwm == 8'd0 && rsp.right_rev_pwm == 8'd0 &&
		rsp.wiper_pwm == 8'd0))
		else $error("motors driven in fault mode");

	a_bridge_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.left_fwd_pwm == 8'd0 || rsp.left_rev_pwm == 8'd0) &&
		(rsp.right_fwd_pwm == 8'd0 || rsp.right_rev_pwm == 8'd0)))
		else $error("both bridge inputs driven");

endmodule
`default_nettype wire

// ===== hdl/dsmc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsmc_front
// Accepts command beats, decodes the function and evaluates the safety inputs.
// ----------------------------------------------------------------------------
module dsmc_front
	import dsmc_pkg::*;
(
	dsmc_cmd_if.sink          cmd,
	input  logic [11:0]       sense_limit,
	input  logic signed [9:0] row_speed,
	output logic              push_valid,
	input  logic              push_ready,
	output work_t             push_data
);

	op_t func_code;

	assign cmd.ready  = push_ready;
	assign push_valid = cmd.valid;
	assign func_code  = op_t'(cmd.func);

	always_comb begin
		case (func_code)
			OP_TICK, OP_PING, OP_STATUS, OP_STOP, OP_ESTOP, OP_CLEAR_FAULT,
			OP_SET_MODE, OP_START_ROW, OP_MANUAL: push_data.op = func_code;
			default: push_data.op = OP_UNKNOWN;
		endcase
		push_data.mode_req   = mode_req_t'(cmd.mode_request);
		push_data.pressed    = !cmd.button_released;
		push_data.unsafe     = (cmd.edge_front_left < sense_limit) ||
			(cmd.edge_front_right < sense_limit) ||
			(cmd.edge_rear_left < sense_limit) ||
			(cmd.edge_rear_right < sense_limit);
		push_data.auto_drive = cmd.speed_given ? cmd.speed : row_speed;
		push_data.drive      = cmd.drive_req;
		push_data.turn       = cmd.turn_req;
		push_data.wipe       = cmd.wipe_req;
	end

endmodule
`default_nettype wire

// ===== hdl/dsmc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsmc_queue
// Small FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
module dsmc_queue
	import dsmc_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	work_t           mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/dsmc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsmc_back
// Executes decoded commands: mode, fault latch, motor commands, PWM duties.
// Holds the response register.
// ----------------------------------------------------------------------------
module dsmc_back
	import dsmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  work_t      pop_data,
	dsmc_rsp_if.source rsp
);

	mode_t             mode_q, mode_nx;
	logic              fault_q, fault_nx;
	logic signed [9:0] drive_q, drive_nx;
	logic signed [9:0] turn_q, turn_nx;
	logic signed [9:0] wipe_q, wipe_nx;
	pwm_t              pwm_q, pwm_nx;
	logic              rsp_valid_q;
	logic              reply_q, reply_nx;
	status_t           status_q, status_nx;
	logic              pong_q, pong_nx;
	logic              edge_q, edge_nx;
	logic              take;
	logic signed [9:0] turn_eff;
	logic signed [9:0] left_trk;
	logic signed [9:0] right_trk;
	pwm_t              run_pwm;

	assign pop_ready = !rsp_valid_q || rsp.ready;
	assign take      = pop_valid && pop_ready;

	// motor update from held commands
	assign turn_eff  = (mode_q == MODE_AUTO) ? 10'sd0 : turn_q;
	assign left_trk  = track_mix(drive_q, turn_eff, 1'b1);
	assign right_trk = track_mix(drive_q, turn_eff, 1'b0);
	always_comb begin
		{run_pwm.left_fwd, run_pwm.left_rev}   = bridge(left_trk);
		{run_pwm.right_fwd, run_pwm.right_rev} = bridge(right_trk);
		run_pwm.wiper                          = wiper_duty(wipe_q);
	end

	always_comb begin
		mode_nx   = mode_q;
		fault_nx  = fault_q;
		drive_nx  = drive_q;
		turn_nx   = turn_q;
		wipe_nx   = wipe_q;
		pwm_nx    = pwm_q;
		reply_nx  = 1'b1;
		status_nx = ST_OK;
		pong_nx   = 1'b0;
		edge_nx   = 1'b0;
		case (pop_data.op)
			OP_TICK: begin
				reply_nx = 1'b0;
				if (pop_data.pressed || (pop_data.unsafe && mode_q != MODE_FAULT)) begin
					reply_nx  = 1'b1;
					status_nx = pop_data.pressed ? ST_BUTTON : ST_EDGE;
					mode_nx   = MODE_FAULT;
					fault_nx  = 1'b1;
					drive_nx  = '0;
					turn_nx   = '0;
					wipe_nx   = '0;
					pwm_nx    = '0;
				end else if (mode_q == MODE_AUTO || mode_q == MODE_MANUAL) begin
					pwm_nx = run_pwm;
				end else begin
					drive_nx = '0;
					turn_nx  = '0;
					wipe_nx  = '0;
					pwm_nx   = '0;
				end
			end
			OP_PING: pong_nx = 1'b1;
			OP_STATUS: edge_nx = pop_data.unsafe;
			OP_STOP: begin
				drive_nx = '0;
				turn_nx  = '0;
				wipe_nx  = '0;
				pwm_nx   = '0;
				if (mode_q != MODE_FAULT) begin
					mode_nx = MODE_IDLE;
				end
			end
			OP_ESTOP: begin
				status_nx = ST_ESTOP;
				mode_nx   = MODE_FAULT;
				fault_nx  = 1'b1;
				drive_nx  = '0;
				turn_nx   = '0;
				wipe_nx   = '0;
				pwm_nx    = '0;
			end
			OP_CLEAR_FAULT: begin
				if (!pop_data.unsafe && !pop_data.pressed) begin
					fault_nx = 1'b0;
					mode_nx  = MODE_IDLE;
				end else begin
					status_nx = ST_UNSAFE;
				end
			end
			OP_SET_MODE: begin
				if (mode_q == MODE_FAULT) begin
					status_nx = ST_BLOCKED;
				end else begin
					case (pop_data.mode_req)
						REQ_IDLE: mode_nx = MODE_IDLE;
						REQ_MANUAL: mode_nx = MODE_MANUAL;
						REQ_AUTO: begin
							mode_nx  = MODE_AUTO;
							drive_nx = pop_data.auto_drive;
							turn_nx  = '0;
							wipe_nx  = WIPE_FULL;
						end
						default: status_nx = ST_BAD;
					endcase
				end
			end
			OP_START_ROW: begin
				if (mode_q == MODE_FAULT) begin
					status_nx = ST_BLOCKED;
				end else begin
					mode_nx  = MODE_AUTO;
					drive_nx = pop_data.auto_drive;
					turn_nx  = '0;
					wipe_nx  = WIPE_FULL;
				end
			end
			OP_MANUAL: begin
				if (mode_q == MODE_FAULT) begin
					status_nx = ST_BLOCKED;
				end else begin
					mode_nx  = MODE_MANUAL;
					drive_nx = pop_data.drive;
					turn_nx  = pop_data.turn;
					wipe_nx  = pop_data.wipe;
				end
			end
			default: status_nx = ST_UNKNOWN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			mode_q      <= MODE_IDLE;
			fault_q     <= 1'b0;
			drive_q     <= '0;
			turn_q      <= '0;
			wipe_q      <= '0;
			pwm_q       <= '0;
		end else begin
			if (take) begin
				rsp_valid_q <= 1'b1;
				mode_q      <= mode_nx;
				fault_q     <= fault_nx;
				drive_q     <= drive_nx;
				turn_q      <= turn_nx;
				wipe_q      <= wipe_nx;
				pwm_q       <= pwm_nx;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			reply_q  <= reply_nx;
			status_q <= status_nx;
			pong_q   <= pong_nx;
			edge_q   <= edge_nx;
		end
	end

	// state registers load only with a new beat, so they double as the held fields
	assign rsp.valid           = rsp_valid_q;
	assign rsp.reply_sent      = reply_q;
	assign rsp.status          = status_q;
	assign rsp.mode_now        = mode_q;
	assign rsp.pong            = pong_q;
	assign rsp.edge_alarm      = edge_q;
	assign rsp.fault_latched   = fault_q;
	assign rsp.left_fwd_pwm    = pwm_q.left_fwd;
	assign rsp.left_rev_pwm    = pwm_q.left_rev;
	assign rsp.right_fwd_pwm   = pwm_q.right_fwd;
	assign rsp.right_rev_pwm   = pwm_q.right_rev;
	assign rsp.wiper_pwm       = pwm_q.wiper;

endmodule
`default_nettype wire
